@@ rtl/rlaq_pkg.sv @@
`default_nettype none
package rlaq_pkg;

   localparam int LINE_BYTES  = 128;
   localparam int QUEUE_LINES = 16;

   localparam int CNT_W  = $clog2(LINE_BYTES + 1);
   localparam int IDX_W  = $clog2(LINE_BYTES);
   localparam int SLOT_W = $clog2(QUEUE_LINES);
   localparam int QCNT_W = $clog2(QUEUE_LINES + 1);
   localparam int STORE_DEPTH = QUEUE_LINES * LINE_BYTES;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   localparam int KIND_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 7;
   localparam int STATUS_W = 3;
   localparam int LEN_W    = 7;

   localparam logic [BYTE_W-1:0] CH_NL = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE   = 2'd0,
      KIND_READ   = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_KEPT    = 3'd0,
      ST_PAST    = 3'd1,
      ST_QUEUED  = 3'd2,
      ST_DROPPED = 3'd3,
      ST_EMPTY   = 3'd4,
      ST_DONE    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COPY,
      S_PUBLISH
   } state_type;

   typedef struct packed {
      logic accept;
      logic copy_run;
      logic publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic line_queued;
      logic copy_done;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

@@ rtl/rx_line_assembler_queue.sv @@
// A transaction's status is registered on acceptance and then loaded into the result
// register in the publish state; a newline that queues a line first copies it byte by byte.
// The next transaction is accepted only after the result loads, so a request is never taken
// while the last one is still in flight, and a stalled result holds off the input until the
// result register is free.
// Reset is synchronous and active high; it empties the line queue and the partial line, and
// no memory clearing pass follows it.
`default_nettype none
module rx_line_assembler_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [rlaq_pkg::KIND_W-1:0]   req_kind,
   input  wire logic [rlaq_pkg::BYTE_W-1:0]   req_rx_byte,
   input  wire logic [rlaq_pkg::OFFSET_W-1:0] req_read_offset,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [rlaq_pkg::STATUS_W-1:0] rsp_status,
   output logic      [rlaq_pkg::BYTE_W-1:0]   rsp_char_out,
   output logic      [rlaq_pkg::LEN_W-1:0]    rsp_line_length,
   output logic      [rlaq_pkg::QCNT_W-1:0]   rsp_lines_queued
);

   rlaq_pkg::ctrl_cmd_type  cmd;
   rlaq_pkg::dp_status_type dp_status;

   rlaq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .dp_status(dp_status),
      .cmd      (cmd)
   );

   rlaq_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .dp_status       (dp_status),
      .req_kind        (req_kind),
      .req_rx_byte     (req_rx_byte),
      .req_read_offset (req_read_offset),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_char_out    (rsp_char_out),
      .rsp_line_length (rsp_line_length),
      .rsp_lines_queued(rsp_lines_queued)
   );

endmodule
`default_nettype wire

@@ rtl/rlaq_ram.sv @@
`default_nettype none
module rlaq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/rlaq_ctrl.sv @@
`default_nettype none
module rlaq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire rlaq_pkg::dp_status_type dp_status,
   output rlaq_pkg::ctrl_cmd_type      cmd
);

   rlaq_pkg::state_type state_ff;
   rlaq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rlaq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rlaq_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = dp_status.line_queued ? rlaq_pkg::S_COPY : rlaq_pkg::S_PUBLISH;
            end
         end
         rlaq_pkg::S_COPY: begin
            if (dp_status.copy_done) begin
               state_in = rlaq_pkg::S_PUBLISH;
            end
         end
         rlaq_pkg::S_PUBLISH: begin
            if (dp_status.out_free) begin
               state_in = rlaq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rlaq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      cmd.accept   = 1'b0;
      cmd.copy_run = 1'b0;
      cmd.publish  = 1'b0;
      unique case (state_ff)
         rlaq_pkg::S_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         rlaq_pkg::S_COPY: begin
            cmd.copy_run = 1'b1;
         end
         rlaq_pkg::S_PUBLISH: begin
            cmd.publish = dp_status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/rlaq_dp.sv @@
`default_nettype none
module rlaq_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rlaq_pkg::ctrl_cmd_type            cmd,
   output rlaq_pkg::dp_status_type                dp_status,
   input  wire logic [rlaq_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [rlaq_pkg::BYTE_W-1:0]       req_rx_byte,
   input  wire logic [rlaq_pkg::OFFSET_W-1:0]     req_read_offset,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [rlaq_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [rlaq_pkg::BYTE_W-1:0]       rsp_char_out,
   output logic      [rlaq_pkg::LEN_W-1:0]        rsp_line_length,
   output logic      [rlaq_pkg::QCNT_W-1:0]       rsp_lines_queued
);

   localparam int CNT_W  = rlaq_pkg::CNT_W;
   localparam int IDX_W  = rlaq_pkg::IDX_W;
   localparam int SLOT_W = rlaq_pkg::SLOT_W;
   localparam int QCNT_W = rlaq_pkg::QCNT_W;
   localparam int LEN_W  = rlaq_pkg::LEN_W;
   localparam int AW     = rlaq_pkg::STORE_AW;

   rlaq_pkg::kind_type kind;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  keep_ff, keep_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [QCNT_W-1:0] lines_ff, lines_in;
   logic [LEN_W-1:0]  lengths_ff [rlaq_pkg::QUEUE_LINES];

   rlaq_pkg::status_type status_ff, status_in;
   logic char_ok_ff, char_ok_in;

   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [IDX_W-1:0]  copy_len_ff, copy_len_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]  wr_idx_ff, wr_idx_in;
   logic              wr_pend_ff, wr_pend_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [rlaq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [rlaq_pkg::BYTE_W-1:0]   rsp_char_ff;
   logic [LEN_W-1:0]          rsp_len_ff;
   logic [QCNT_W-1:0]         rsp_lines_ff;

   logic              line_fits;
   logic [CNT_W-1:0]  strip_len;
   logic [SLOT_W:0]   tail_sum;
   logic [SLOT_W-1:0] tail_slot;
   logic              is_nl;
   logic              copy_rd;
   logic              lengths_we;

   logic                       part_we;
   logic [IDX_W-1:0]           part_waddr;
   logic [rlaq_pkg::BYTE_W-1:0] part_rdata;
   logic                       store_we;
   logic [AW-1:0]              store_waddr;
   logic                       store_re;
   logic [AW-1:0]              store_raddr;
   logic [rlaq_pkg::BYTE_W-1:0] store_rdata;

   assign kind      = rlaq_pkg::kind_type'(req_kind);
   assign is_nl     = (req_rx_byte == rlaq_pkg::CH_NL);
   assign line_fits = (count_ff < CNT_W'(rlaq_pkg::LINE_BYTES - 1)) &&
                      (lines_ff < QCNT_W'(rlaq_pkg::QUEUE_LINES));
   assign strip_len = (keep_ff > count_ff) ? count_ff : keep_ff;
   assign tail_sum  = (SLOT_W + 1)'(head_ff) + (SLOT_W + 1)'(lines_ff);
   assign tail_slot = (tail_sum >= (SLOT_W + 1)'(rlaq_pkg::QUEUE_LINES)) ?
                      SLOT_W'(tail_sum - (SLOT_W + 1)'(rlaq_pkg::QUEUE_LINES)) :
                      SLOT_W'(tail_sum);

   assign dp_status.line_queued = (kind == rlaq_pkg::KIND_BYTE) && is_nl && line_fits;
   assign dp_status.copy_done   = (rd_idx_ff >= copy_len_ff) && !wr_pend_ff;
   assign dp_status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign copy_rd    = cmd.copy_run && (rd_idx_ff < copy_len_ff);
   assign lengths_we = cmd.accept && dp_status.line_queued;

   always_comb begin
      count_in    = count_ff;
      keep_in     = keep_ff;
      head_in     = head_ff;
      lines_in    = lines_ff;
      status_in   = status_ff;
      char_ok_in  = char_ok_ff;
      tail_in     = tail_ff;
      copy_len_in = copy_len_ff;
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      wr_pend_in  = 1'b0;
      part_we     = 1'b0;
      part_waddr  = IDX_W'(count_ff);
      store_re    = 1'b0;
      store_raddr = AW'(head_ff) * AW'(rlaq_pkg::LINE_BYTES) + AW'(req_read_offset);
      if (cmd.accept) begin
         char_ok_in = 1'b0;
         status_in  = rlaq_pkg::ST_DONE;
         case (kind)
            rlaq_pkg::KIND_BYTE: begin
               if (is_nl) begin
                  count_in = '0;
                  keep_in  = '0;
                  if (line_fits) begin
                     status_in   = rlaq_pkg::ST_QUEUED;
                     lines_in    = lines_ff + QCNT_W'(1);
                     tail_in     = tail_slot;
                     copy_len_in = IDX_W'(strip_len);
                     rd_idx_in   = '0;
                  end else begin
                     status_in = rlaq_pkg::ST_DROPPED;
                  end
               end else if (count_ff < CNT_W'(rlaq_pkg::LINE_BYTES)) begin
                  status_in = rlaq_pkg::ST_KEPT;
                  part_we   = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
                  if (req_rx_byte != rlaq_pkg::CH_CR) begin
                     keep_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  status_in = rlaq_pkg::ST_PAST;
               end
            end
            rlaq_pkg::KIND_READ: begin
               if (lines_ff == '0) begin
                  status_in = rlaq_pkg::ST_EMPTY;
               end else begin
                  store_re   = 1'b1;
                  char_ok_in = (req_read_offset < lengths_ff[head_ff]);
               end
            end
            rlaq_pkg::KIND_REMOVE: begin
               if (lines_ff == '0) begin
                  status_in = rlaq_pkg::ST_EMPTY;
               end else begin
                  lines_in = lines_ff - QCNT_W'(1);
                  head_in  = (head_ff == SLOT_W'(rlaq_pkg::QUEUE_LINES - 1)) ?
                             '0 : head_ff + SLOT_W'(1);
               end
            end
            default: begin
               status_in = rlaq_pkg::ST_DONE;
            end
         endcase
      end
      if (copy_rd) begin
         rd_idx_in  = rd_idx_ff + IDX_W'(1);
         wr_idx_in  = rd_idx_ff;
         wr_pend_in = 1'b1;
      end
   end

   assign store_we    = wr_pend_ff;
   assign store_waddr = AW'(tail_ff) * AW'(rlaq_pkg::LINE_BYTES) + AW'(wr_idx_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         keep_ff      <= '0;
         head_ff      <= '0;
         lines_ff     <= '0;
         wr_pend_ff   <= 1'b0;
         rd_idx_ff    <= '0;
         copy_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         keep_ff      <= keep_in;
         head_ff      <= head_in;
         lines_ff     <= lines_in;
         wr_pend_ff   <= wr_pend_in;
         rd_idx_ff    <= rd_idx_in;
         copy_len_ff  <= copy_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      char_ok_ff <= char_ok_in;
      tail_ff    <= tail_in;
      wr_idx_ff  <= wr_idx_in;
      if (lengths_we) begin
         lengths_ff[tail_slot] <= LEN_W'(strip_len);
      end
      if (cmd.publish) begin
         rsp_status_ff <= status_ff;
         rsp_char_ff   <= char_ok_ff ? store_rdata : '0;
         rsp_len_ff    <= (lines_ff != '0) ? lengths_ff[head_ff] : '0;
         rsp_lines_ff  <= lines_ff;
      end
   end

   rlaq_ram #(
      .WIDTH(rlaq_pkg::BYTE_W),
      .DEPTH(rlaq_pkg::LINE_BYTES)
   ) u_partial_ram (
      .clock  (clock),
      .wr_en  (part_we),
      .wr_addr(part_waddr),
      .wr_data(req_rx_byte),
      .rd_en  (copy_rd),
      .rd_addr(rd_idx_ff),
      .rd_data(part_rdata)
   );

   rlaq_ram #(
      .WIDTH(rlaq_pkg::BYTE_W),
      .DEPTH(rlaq_pkg::STORE_DEPTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (store_we),
      .wr_addr(store_waddr),
      .wr_data(part_rdata),
      .rd_en  (store_re),
      .rd_addr(store_raddr),
      .rd_data(store_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_char_out     = rsp_char_ff;
   assign rsp_line_length  = rsp_len_ff;
   assign rsp_lines_queued = rsp_lines_ff;

endmodule
`default_nettype wire
